// ----- sv/mt_pkg.sv -----
// mt_pkg: shared types, constants and control structs for the mt19937 random source
// no dependencies
`timescale 1ns / 1ps
package mt_pkg;

    localparam int unsigned STATE_WORDS_DEF   = 624;
    localparam int unsigned MIDDLE_OFFSET_DEF = 397;
    localparam int unsigned KEY_WORDS_DEF     = 1;

    localparam logic [31:0] INIT_MULT    = 32'd1812433253;
    localparam logic [31:0] INIT_SEED    = 32'd19650218;
    localparam logic [31:0] MIX_MULT_A   = 32'd1664525;
    localparam logic [31:0] MIX_MULT_B   = 32'd1566083941;
    localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
    localparam logic [31:0] HIGH_BIT     = 32'h80000000;
    localparam logic [31:0] LOW_BITS     = 32'h7fffffff;
    localparam logic [31:0] TEMPER_B     = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C     = 32'hefc60000;

    typedef enum logic [2:0] {
        OP_RESEED = 3'd0,
        OP_WORD32 = 3'd1,
        OP_TOPK   = 3'd2,
        OP_BIT    = 3'd3,
        OP_V53    = 3'd4,
        OP_BERN   = 3'd5
    } t_opcode;

    // datapath micro-operations
    typedef enum logic [3:0] {
        DP_NOP,
        DP_FILL_RD,    // read word n-1 for linear fill
        DP_FILL_MUL,   // multiply
        DP_FILL_WR,    // write word n
        DP_MIX_RD,     // read words i-1 and i
        DP_MIX_MUL,
        DP_MIX_WR,     // write word i
        DP_FIX0_RD,    // read last word
        DP_FIX0_WR,    // copy into word 0
        DP_HIGH_WR,    // word 0 := high bit
        DP_TW_RD,      // read n+1 and n+m, word n carried over
        DP_TW_WR,
        DP_WORD_RD,    // read word at index
        DP_WORD_TMP    // temper and latch
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        logic       mix_b;     // second mixing pass
        logic       clr_idx;   // read index back to 0 after twist
        logic       set_full;  // read index := state words
        logic       save_a;    // keep tempered word as first half
        logic [1:0] res_sel;   // 0 hold (cleared on load), 1 word/topk, 2 bit, 3 v53/bern
    } t_dp_cmd;

    typedef struct packed {
        logic ctr_last;   // loop counter on its final count
        logic idx_full;   // read index reached state words
        logic bit_rej;    // 2-bit draw was 2 or 3
        logic k_zero;     // effective bit count is zero
    } t_dp_sts;

    typedef enum logic [4:0] {
        S_IDLE, S_F_RD, S_F_MUL, S_F_WR,
        S_A_RD, S_A_MUL, S_A_WR, S_A_FX_RD, S_A_FX_WR,
        S_B_RD, S_B_MUL, S_B_WR, S_B_FX_RD, S_B_FX_WR, S_HIGH,
        S_CHK, S_T_RD, S_T_WR, S_W_RD, S_W_TMP, S_DONE, S_OUT
    } t_state;

endpackage

// ----- sv/mt_datapath.sv -----
// mt_datapath: state memory, loop counters, multiplier, tempering and result register
// depends on mt_pkg
`timescale 1ns / 1ps
module mt_datapath #(
    parameter int unsigned STATE_WORDS   = mt_pkg::STATE_WORDS_DEF,
    parameter int unsigned MIDDLE_OFFSET = mt_pkg::MIDDLE_OFFSET_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mt_pkg::t_dp_cmd i_cmd,
    input  logic            i_load,
    input  logic [2:0]      i_opcode,
    input  logic [5:0]      i_bit_count,
    input  logic [53:0]     i_threshold,
    input  logic [31:0]     i_seed_word,
    output mt_pkg::t_dp_sts o_sts,
    output logic [52:0]     o_value
);
    import mt_pkg::*;

    localparam int AW = $clog2(STATE_WORDS + 1);
    localparam logic [AW-1:0] LAST = AW'(STATE_WORDS - 1);
    localparam logic [AW-1:0] FULL = AW'(STATE_WORDS);
    localparam logic [AW-1:0] MOFF = AW'(MIDDLE_OFFSET);

    logic [31:0] r_mem [STATE_WORDS];
    logic [31:0] r_ra, r_rb, r_rc;
    logic [AW-1:0] r_ctr, n_ctr, r_idx;
    logic [31:0] r_prod, r_tw;
    logic [26:0] r_a;
    logic [5:0]  r_k;
    logic [2:0]  r_op;
    logic [53:0] r_thr;
    logic [52:0] r_val;

    logic [AW-1:0] ctr_p1, ctr_m1, ctr_pm, adr_a, adr_b, wadr;
    logic [31:0] pa, y, mixed, t1, t2, t3, t4, wdata;
    logic        we;
    logic [5:0]  keff;
    logic [52:0] v53;

    assign ctr_p1 = (r_ctr == LAST) ? '0 : r_ctr + 1'b1;
    assign ctr_m1 = r_ctr - 1'b1;
    assign ctr_pm = (r_ctr >= FULL - MOFF) ? r_ctr + MOFF - FULL : r_ctr + MOFF;
    assign pa = r_ra ^ (r_ra >> 30);
    // r_rc holds word n, r_rb word n+1, r_ra word n+m
    assign y = (r_rc & HIGH_BIT) | (r_rb & LOW_BITS);
    assign mixed = r_ra ^ (y >> 1) ^ (y[0] ? TWIST_MATRIX : 32'd0);
    assign t1 = r_ra ^ (r_ra >> 11);
    assign t2 = t1 ^ ((t1 << 7) & TEMPER_B);
    assign t3 = t2 ^ ((t2 << 15) & TEMPER_C);
    assign t4 = t3 ^ (t3 >> 18);
    assign keff = (r_k > 6'd32) ? 6'd32 : r_k;
    assign v53 = {r_a, r_tw[31:6]};

    always_comb begin
        adr_a = r_ctr;
        adr_b = r_ctr;
        wadr  = r_ctr;
        wdata = r_prod;
        we    = 1'b0;
        n_ctr = r_ctr;
        case (i_cmd.op)
            DP_FILL_RD: adr_a = ctr_m1;
            DP_FILL_WR: begin
                we = 1'b1;
                wdata = (r_ctr == '0) ? INIT_SEED : r_prod + 32'(r_ctr);
                n_ctr = (r_ctr == LAST) ? AW'(1) : r_ctr + 1'b1;
            end
            DP_MIX_RD: begin
                adr_a = ctr_m1;
                adr_b = r_ctr;
            end
            DP_MIX_WR: begin
                we = 1'b1;
                wdata = i_cmd.mix_b ? (r_rb ^ r_prod) - 32'(r_ctr)
                                    : (r_rb ^ r_prod) + i_seed_word;
                n_ctr = r_ctr + 1'b1;
            end
            DP_FIX0_RD: adr_a = LAST;
            DP_FIX0_WR: begin
                we = 1'b1;
                wadr = '0;
                wdata = r_ra;
                n_ctr = AW'(1);
            end
            DP_HIGH_WR: begin
                we = 1'b1;
                wadr = '0;
                wdata = HIGH_BIT;
                n_ctr = '0;
            end
            DP_TW_RD: begin
                adr_a = ctr_pm;
                adr_b = ctr_p1;
            end
            DP_TW_WR: begin
                we = 1'b1;
                wdata = mixed;
                n_ctr = (r_ctr == LAST) ? '0 : r_ctr + 1'b1;
            end
            DP_WORD_RD: adr_a = r_idx;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[wadr[AW-1:0]] <= wdata;
        r_ra <= r_mem[adr_a];
        r_rb <= r_mem[adr_b];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_FILL_MUL) r_prod <= INIT_MULT * pa;
        if (i_cmd.op == DP_MIX_MUL)  r_prod <= (i_cmd.mix_b ? MIX_MULT_B : MIX_MULT_A) * pa;
        // word 0 comes from the read made in the index check cycle
        if (i_cmd.op == DP_TW_WR) r_rc <= r_rb;
        else if (i_cmd.op == DP_TW_RD && r_ctr == '0) r_rc <= r_ra;
        if (i_cmd.op == DP_WORD_TMP) r_tw <= t4;
        if (i_cmd.save_a) r_a <= r_tw[31:5];
        if (i_load) begin
            r_k   <= i_bit_count;
            r_op  <= i_opcode;
            r_thr <= i_threshold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr <= '0;
            r_idx <= FULL;
            r_val <= '0;
        end else begin
            r_ctr <= (i_load || i_cmd.clr_idx) ? '0 : n_ctr;
            if (i_cmd.clr_idx) r_idx <= '0;
            else if (i_cmd.set_full) r_idx <= FULL;
            else if (i_cmd.op == DP_WORD_TMP) r_idx <= r_idx + 1'b1;
            case (i_cmd.res_sel)
                2'd1: r_val <= (r_op == OP_WORD32) ? 53'(r_tw)
                             : (keff == 6'd0) ? '0 : 53'(r_tw >> (6'd32 - keff));
                2'd2: r_val <= 53'(r_tw[31:30]);
                2'd3: r_val <= (r_op == OP_V53) ? v53
                             : ((54'(v53) < r_thr) ? 53'd1 : 53'd0);
                default: if (i_load) r_val <= '0;
            endcase
        end
    end

    assign o_sts.ctr_last = (r_ctr == LAST);
    assign o_sts.idx_full = (r_idx == FULL);
    assign o_sts.bit_rej  = r_tw[31];
    assign o_sts.k_zero   = (keff == 6'd0);
    assign o_value = r_val;

endmodule

// ----- sv/mt_ctrl.sv -----
// mt_ctrl: request sequencer for seeding, twisting and draws
// depends on mt_pkg
`timescale 1ns / 1ps
module mt_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  logic [2:0]      i_opcode,
    input  logic [5:0]      i_bit_count,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    input  mt_pkg::t_dp_sts i_sts,
    output mt_pkg::t_dp_cmd o_cmd,
    output logic            o_load
);
    import mt_pkg::*;

    t_state r_state, n_state;
    logic [2:0] r_op, n_op;
    logic r_seeded, n_seeded, r_half, n_half, r_ov, n_ov;
    logic acc;

    assign o_in_stall = (r_state != S_IDLE) || (r_ov && i_out_stall);
    assign acc = i_in_valid && !o_in_stall;
    assign o_load = acc;
    assign o_out_valid = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op <= '0;
            r_seeded <= 1'b0;
            r_half <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            r_state <= n_state;
            r_op <= n_op;
            r_seeded <= n_seeded;
            r_half <= n_half;
            r_ov <= n_ov;
        end
    end

    always_comb begin
        n_state = r_state;
        n_op = r_op;
        n_seeded = r_seeded;
        n_half = r_half;
        n_ov = r_ov && i_out_stall;
        o_cmd = '0;
        o_cmd.op = DP_NOP;
        case (r_state)
            S_IDLE: if (acc) begin
                n_op = i_opcode;
                n_half = 1'b0;
                if (i_opcode == OP_RESEED) n_state = S_F_WR;
                else if (i_opcode > OP_BERN) n_state = S_OUT;
                else if (i_opcode == OP_TOPK && i_bit_count == 6'd0)
                    n_state = r_seeded ? S_OUT : S_F_WR;
                else n_state = r_seeded ? S_CHK : S_F_WR;
            end
            S_F_RD: begin o_cmd.op = DP_FILL_RD; n_state = S_F_MUL; end
            S_F_MUL: begin o_cmd.op = DP_FILL_MUL; n_state = S_F_WR; end
            S_F_WR: begin
                o_cmd.op = DP_FILL_WR;
                n_state = i_sts.ctr_last ? S_A_RD : S_F_RD;
            end
            S_A_RD: begin o_cmd.op = DP_MIX_RD; n_state = S_A_MUL; end
            S_A_MUL: begin o_cmd.op = DP_MIX_MUL; n_state = S_A_WR; end
            S_A_WR: begin
                o_cmd.op = DP_MIX_WR;
                if (r_half) begin
                    n_state = S_B_RD;
                    n_half = 1'b0;
                end else n_state = i_sts.ctr_last ? S_A_FX_RD : S_A_RD;
            end
            S_A_FX_RD: begin o_cmd.op = DP_FIX0_RD; n_state = S_A_FX_WR; end
            S_A_FX_WR: begin
                o_cmd.op = DP_FIX0_WR;
                // key pass covers 624 steps: one more after wrap
                n_state = S_A_RD;
                n_half = 1'b1;
            end
            S_B_RD: begin o_cmd.op = DP_MIX_RD; o_cmd.mix_b = 1'b1; n_state = S_B_MUL; end
            S_B_MUL: begin o_cmd.op = DP_MIX_MUL; o_cmd.mix_b = 1'b1; n_state = S_B_WR; end
            S_B_WR: begin
                o_cmd.op = DP_MIX_WR;
                o_cmd.mix_b = 1'b1;
                if (r_half) n_state = S_HIGH;
                else n_state = i_sts.ctr_last ? S_B_FX_RD : S_B_RD;
            end
            S_B_FX_RD: begin o_cmd.op = DP_FIX0_RD; n_state = S_B_FX_WR; end
            S_B_FX_WR: begin
                o_cmd.op = DP_FIX0_WR;
                n_state = S_B_RD;
                n_half = 1'b1;
            end
            S_HIGH: begin
                o_cmd.op = DP_HIGH_WR;
                o_cmd.set_full = 1'b1;
                n_seeded = 1'b1;
                n_half = 1'b0;
                if (r_op == OP_RESEED || (r_op == OP_TOPK && i_sts.k_zero)) n_state = S_DONE;
                else n_state = S_CHK;
            end
            S_CHK: n_state = i_sts.idx_full ? S_T_RD : S_W_RD;
            S_T_RD: begin o_cmd.op = DP_TW_RD; n_state = S_T_WR; end
            S_T_WR: begin
                o_cmd.op = DP_TW_WR;
                if (i_sts.ctr_last) begin
                    o_cmd.clr_idx = 1'b1;
                    n_state = S_W_RD;
                end else n_state = S_T_RD;
            end
            S_W_RD: begin o_cmd.op = DP_WORD_RD; n_state = S_W_TMP; end
            S_W_TMP: begin o_cmd.op = DP_WORD_TMP; n_state = S_DONE; end
            S_DONE: begin
                n_state = S_OUT;
                case (r_op)
                    OP_WORD32: o_cmd.res_sel = 2'd1;
                    OP_TOPK: o_cmd.res_sel = 2'd1;
                    OP_BIT: if (i_sts.bit_rej) n_state = S_CHK;
                            else o_cmd.res_sel = 2'd2;
                    OP_V53, OP_BERN: if (!r_half) begin
                        o_cmd.save_a = 1'b1;
                        n_half = 1'b1;
                        n_state = S_CHK;
                    end else o_cmd.res_sel = 2'd3;
                    default: ;
                endcase
            end
            S_OUT: if (!(r_ov && i_out_stall)) begin
                n_ov = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ----- sv/mt19937_random_source_top.sv -----
// mt19937_random_source_top: mt19937 random source with seed register
// depends on mt_pkg, mt_ctrl, mt_datapath
`timescale 1ns / 1ps
// One request in, one result out. Each 32-bit word of a draw passes index check,
// memory read, tempering and result, and a 53-bit value takes two words; every 624
// words a twist first rewrites the state, each word read and then written through
// the single state memory. A reseed, or the first draw after reset, first runs the
// seeding sequencer. The result is held in an output register; a new request is
// taken once the block is idle and that register is free.
module mt19937_random_source_top #(
    parameter int unsigned STATE_WORDS   = mt_pkg::STATE_WORDS_DEF,
    parameter int unsigned MIDDLE_OFFSET = mt_pkg::MIDDLE_OFFSET_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic [5:0]  i_bit_count,
    input  logic [53:0] i_threshold,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [52:0] o_value
);
    import mt_pkg::*;

    logic [31:0] r_seed_word;
    t_dp_cmd cmd;
    t_dp_sts sts;
    logic load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_seed_word <= '0;
        else if (i_cfg_we) r_seed_word <= i_cfg_wdata;
    end

    mt_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_in_valid, .o_in_stall, .i_opcode, .i_bit_count,
        .o_out_valid, .i_out_stall, .i_sts(sts), .o_cmd(cmd), .o_load(load)
    );

    mt_datapath #(.STATE_WORDS(STATE_WORDS), .MIDDLE_OFFSET(MIDDLE_OFFSET)) u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_load(load), .i_opcode, .i_bit_count,
        .i_threshold, .i_seed_word(r_seed_word), .o_sts(sts), .o_value
    );

endmodule

// ----- bench/tb_mt19937_random_source_top.sv -----
// tb_mt19937_random_source_top: self-checking bench for the mt19937 random source
// holds its own twister predictor, a directed table and random traffic with idling
// depends on mt_pkg and mt19937_random_source_top
`timescale 1ns / 1ps
module tb_mt19937_random_source_top;
    import mt_pkg::*;

    localparam int unsigned NWORDS = STATE_WORDS_DEF;
    localparam int unsigned MOFF   = MIDDLE_OFFSET_DEF;
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;
    localparam logic [53:0] TWO53 = 54'h20_0000_0000_0000;
    localparam logic [53:0] ALL54 = 54'h3F_FFFF_FFFF_FFFF;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_wdata;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_opcode;
    logic [5:0]  i_bit_count;
    logic [53:0] i_threshold;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [52:0] o_value;

    mt19937_random_source_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_bit_count (i_bit_count),
        .i_threshold (i_threshold),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_value     (o_value)
    );

    // predictor state
    bit [31:0] mt_words [NWORDS];
    int unsigned mt_idx;
    bit mt_seeded;
    bit [31:0] mt_seed;

    logic [52:0] expected_values [$];
    int unsigned fail_count;
    int unsigned in_idle_pct;
    int unsigned out_idle_pct;
    bit long_hold_req;

    typedef struct {
        logic [2:0]  op;
        logic [5:0]  k;
        logic [53:0] thr;
        bit          known;
        logic [52:0] val;
    } t_row;

    t_row directed_rows [] = '{
        '{OP_WORD32, 6'd0,  54'd0, 1'b0, 53'd0},
        '{OP_RESEED, 6'd0,  54'd0, 1'b1, 53'd0},
        '{OP_WORD32, 6'd0,  54'd0, 1'b0, 53'd0},
        '{OP_SPARE6, 6'd63, ALL54, 1'b1, 53'd0},
        '{OP_SPARE7, 6'd0,  ALL54, 1'b1, 53'd0},
        '{OP_TOPK,   6'd0,  54'd0, 1'b1, 53'd0},
        '{OP_TOPK,   6'd1,  54'd0, 1'b0, 53'd0},
        '{OP_TOPK,   6'd32, 54'd0, 1'b0, 53'd0},
        '{OP_TOPK,   6'd33, 54'd0, 1'b0, 53'd0},
        '{OP_TOPK,   6'd63, 54'd0, 1'b0, 53'd0},
        '{OP_BIT,    6'd0,  54'd0, 1'b0, 53'd0},
        '{OP_BIT,    6'd0,  54'd0, 1'b0, 53'd0},
        '{OP_V53,    6'd0,  54'd0, 1'b0, 53'd0},
        '{OP_BERN,   6'd0,  54'd0, 1'b1, 53'd0},
        '{OP_BERN,   6'd0,  TWO53, 1'b1, 53'd1},
        '{OP_BERN,   6'd0,  ALL54, 1'b1, 53'd1},
        '{OP_BERN,   6'd0,  54'h10_0000_0000_0000, 1'b0, 53'd0},
        '{OP_BERN,   6'd0,  54'd1, 1'b0, 53'd0},
        '{OP_RESEED, 6'd5,  ALL54, 1'b1, 53'd0},
        '{OP_V53,    6'd0,  54'd0, 1'b0, 53'd0}
    };

    function automatic void mt_reseed();
        bit [31:0] i, j, p;
        int cnt;
        mt_words[0] = INIT_SEED;
        for (int n = 1; n < NWORDS; n++) begin
            p = mt_words[n-1];
            mt_words[n] = INIT_MULT * (p ^ (p >> 30)) + 32'(n);
        end
        i = 1;
        j = 0;
        for (cnt = NWORDS; cnt > 0; cnt--) begin
            p = mt_words[i-1];
            mt_words[i] = (mt_words[i] ^ ((p ^ (p >> 30)) * MIX_MULT_A)) + mt_seed + j;
            i++;
            if (i >= NWORDS) begin
                mt_words[0] = mt_words[NWORDS-1];
                i = 1;
            end
        end
        for (cnt = NWORDS - 1; cnt > 0; cnt--) begin
            p = mt_words[i-1];
            mt_words[i] = (mt_words[i] ^ ((p ^ (p >> 30)) * MIX_MULT_B)) - i;
            i++;
            if (i >= NWORDS) begin
                mt_words[0] = mt_words[NWORDS-1];
                i = 1;
            end
        end
        mt_words[0] = HIGH_BIT;
        mt_idx = NWORDS;
        mt_seeded = 1'b1;
    endfunction

    function automatic bit [31:0] mt_next_word();
        bit [31:0] y, mixed;
        if (mt_idx >= NWORDS) begin
            for (int n = 0; n < NWORDS; n++) begin
                y = (mt_words[n] & HIGH_BIT) | (mt_words[(n+1) % NWORDS] & LOW_BITS);
                mixed = mt_words[(n + MOFF) % NWORDS] ^ (y >> 1);
                if (y[0]) mixed ^= TWIST_MATRIX;
                mt_words[n] = mixed;
            end
            mt_idx = 0;
        end
        y = mt_words[mt_idx];
        mt_idx++;
        y ^= y >> 11;
        y ^= (y << 7) & TEMPER_B;
        y ^= (y << 15) & TEMPER_C;
        y ^= y >> 18;
        return y;
    endfunction

    function automatic bit [52:0] mt_draw53();
        bit [52:0] a, b;
        a = 53'(mt_next_word() >> 5);
        b = 53'(mt_next_word() >> 6);
        return (a << 26) | b;
    endfunction

    function automatic logic [52:0] predict_value(logic [2:0] op, logic [5:0] k,
                                                  logic [53:0] thr);
        bit [31:0] w;
        int unsigned kk;
        if (op == OP_RESEED) begin
            mt_reseed();
            return '0;
        end
        if (op > OP_BERN) return '0;
        if (!mt_seeded) mt_reseed();
        case (op)
            OP_WORD32: return 53'(mt_next_word());
            OP_TOPK: begin
                kk = (k > 32) ? 32 : k;
                if (kk == 0) return '0;
                w = mt_next_word();
                return 53'(w >> (32 - kk));
            end
            OP_BIT: begin
                forever begin
                    w = mt_next_word() >> 30;
                    if (w < 2) return 53'(w);
                end
            end
            OP_V53: return mt_draw53();
            default: return ({1'b0, mt_draw53()} < thr) ? 53'd1 : 53'd0;
        endcase
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    // receiver side, with one long hold-off on request
    initial begin
        int unsigned hold_left;
        hold_left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req && hold_left == 0) begin
                long_hold_req = 1'b0;
                hold_left = 600;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < out_idle_pct);
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_values.size() == 0) begin
                $display("%0t unexpected transfer, actual %h", $realtime, o_value);
                fail_count++;
            end else begin
                logic [52:0] exp_val;
                exp_val = expected_values.pop_front();
                if (o_value !== exp_val) begin
                    $display("%0t value mismatch, expected %h actual %h",
                             $realtime, exp_val, o_value);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_request(logic [2:0] op, logic [5:0] k, logic [53:0] thr,
                                bit known, logic [52:0] val);
        logic [52:0] pred;
        while ($urandom_range(0, 99) < in_idle_pct) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_opcode    <= op;
        i_bit_count <= k;
        i_threshold <= thr;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        pred = predict_value(op, k, thr);
        if (known && pred !== val) begin
            $display("%0t table expectation disagrees, expected %h predicted %h",
                     $realtime, val, pred);
            fail_count++;
        end
        expected_values.push_back(known ? val : pred);
    endtask

    task automatic drain_and_write_seed(bit [31:0] seed);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_values.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= seed;
        mt_seed = seed;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_requests(int unsigned count);
        logic [2:0]  op;
        logic [5:0]  k;
        logic [53:0] thr;
        int unsigned pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 1) op = OP_RESEED;
            else if (pick < 3) op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;
            else op = 3'($urandom_range(1, 5));
            k = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(1, 32));
            case ($urandom_range(0, 3))
                0: thr = 54'({$urandom, $urandom});
                1: thr = 54'({$urandom, $urandom} & 64'h1F_FFFF_FFFF_FFFF);
                2: thr = 54'($urandom_range(0, 1)) << 53 | 54'($urandom_range(0, 3));
                default: thr = TWO53 - 54'($urandom);
            endcase
            send_request(op, k, thr, 1'b0, '0);
        end
    endtask

    initial begin
        fail_count    = 0;
        in_idle_pct   = 0;
        out_idle_pct  = 0;
        long_hold_req = 1'b0;
        mt_seed       = '0;
        mt_idx        = NWORDS;
        mt_seeded     = 1'b0;
        foreach (mt_words[n]) mt_words[n] = '0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_opcode    = '0;
        i_bit_count = '0;
        i_threshold = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table under the reset seed, then the all-ones seed
        foreach (directed_rows[r])
            send_request(directed_rows[r].op, directed_rows[r].k, directed_rows[r].thr,
                         directed_rows[r].known, directed_rows[r].val);
        drain_and_write_seed(32'hFFFF_FFFF);
        send_request(OP_RESEED, 6'd0, 54'd0, 1'b1, 53'd0);

        in_idle_pct  = 28;
        out_idle_pct = 72;
        random_requests(440);

        drain_and_write_seed($urandom);
        in_idle_pct  = 72;
        out_idle_pct = 28;
        send_request(OP_RESEED, 6'd0, 54'd0, 1'b1, 53'd0);
        random_requests(440);

        drain_and_write_seed(32'd0);
        in_idle_pct  = 0;
        out_idle_pct = 0;
        long_hold_req = 1'b1;
        send_request(OP_RESEED, 6'd0, 54'd0, 1'b1, 53'd0);
        random_requests(440);

        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (expected_values.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
